FILE: rtl/psev_pkg.sv
package psev_pkg;

  // field widths and default stack size
  localparam int DATA_W          = 32;
  localparam int CMD_W           = 3;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FINISH = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd3;

  // input word
  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] operand_value;
  } psev_in_t;

  // result word
  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [STATUS_W-1:0]      status;
    logic                     is_final;
  } psev_out_t;

  // control from sequencer to serial arithmetic unit
  typedef struct packed {
    logic             start;
    logic [CMD_W-1:0] op;
  } psev_alu_ctl_t;

endpackage

FILE: rtl/psev_ram.sv
module psev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/psev_alu.sv
module psev_alu (
  input  logic                            clk,
  input  logic                            rst_n,
  input  psev_pkg::psev_alu_ctl_t         ctl,
  input  logic [psev_pkg::DATA_W-1:0]     a,
  input  logic [psev_pkg::DATA_W-1:0]     b,
  output logic                            done,
  output logic [psev_pkg::DATA_W-1:0]     result
);
  import psev_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

  logic [DATA_W-1:0] a_r, a_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic              carry_r, carry_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CMD_W-1:0]  op_r, op_nxt;
  logic              neg_r, neg_nxt;

  // one restoring division step
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W+1:0] diff;
  logic              qbit;
  logic              sum_bit;

  assign rem_sh  = {acc_r, a_r[DATA_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, b_r};
  assign qbit    = ~diff[DATA_W+1];
  assign sum_bit = a_r[0] ^ b_r[0] ^ carry_r;

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    carry_nxt = carry_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    neg_nxt   = neg_r;
    if (ctl.start) begin
      // load operands for the chosen operation
      op_nxt  = ctl.op;
      run_nxt = 1'b1;
      cnt_nxt = '0;
      acc_nxt = '0;
      unique case (ctl.op)
        CMD_ADD: begin
          a_nxt     = a;
          b_nxt     = b;
          carry_nxt = 1'b0;
        end
        CMD_SUB: begin
          a_nxt     = a;
          b_nxt     = ~b;
          carry_nxt = 1'b1;
        end
        CMD_MUL: begin
          a_nxt = a;
          b_nxt = b;
        end
        default: begin
          a_nxt   = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
          b_nxt   = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
          neg_nxt = a[DATA_W-1] ^ b[DATA_W-1];
        end
      endcase
    end else if (run_r) begin
      // one bit per cycle
      unique case (op_r)
        CMD_ADD, CMD_SUB: begin
          acc_nxt   = {sum_bit, acc_r[DATA_W-1:1]};
          carry_nxt = (a_r[0] & b_r[0]) | (carry_r & (a_r[0] ^ b_r[0]));
          a_nxt     = a_r >> 1;
          b_nxt     = b_r >> 1;
        end
        CMD_MUL: begin
          acc_nxt = acc_r + (b_r[0] ? a_r : '0);
          a_nxt   = a_r << 1;
          b_nxt   = b_r >> 1;
        end
        default: begin
          acc_nxt = qbit ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
          a_nxt   = {a_r[DATA_W-2:0], qbit};
        end
      endcase
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    carry_r <= carry_nxt;
    op_r    <= op_nxt;
    neg_r   <= neg_nxt;
  end

  // quotient sits in a_r, everything else in acc_r
  assign done   = done_r;
  assign result = (op_r == CMD_DIV) ? (neg_r ? (~a_r + DATA_W'(1)) : a_r) : acc_r;

endmodule

FILE: rtl/postfix_stack_evaluator_unit.sv
// Postfix integer evaluator on an operand stack held in a single-port-read RAM.
// Raise start with a word on in_word while busy is low; every word gives exactly one
// result, shown on out_word for one cycle with out_strobe high, which the receiver
// must take then. Push, unused commands, overflow and underflow finish in the accept
// cycle, so a new word can follow on the next cycle. Finish waits in S_FIN for the
// stack read. Add, subtract, multiply and divide go through two reads of the
// stack RAM through its one registered read port, one operand load, 32 steps of the
// bit-serial arithmetic unit and one write-back; a division by zero is caught after
// the two reads. Division truncates toward zero; division by zero, overflow and
// underflow are flagged and leave the stack as it was. No clearing pass runs after
// reset.
module postfix_stack_evaluator_unit #(
  parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psev_pkg::psev_in_t  in_word,
  output logic                out_strobe,
  output psev_pkg::psev_out_t out_word
);
  import psev_pkg::*;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_L = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [CMD_W-1:0]  op_r, op_nxt;
  logic [DATA_W-1:0] right_r, right_nxt;
  logic              strobe_r, strobe_nxt;
  psev_out_t         word_r, word_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  psev_alu_ctl_t     alu_ctl;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;

  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign cnt_m2 = cnt_r - CNT_W'(2);

  // right operand first, then left
  assign raddr = (state_r == S_RD_L) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];

  psev_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  psev_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .a      (rdata),
    .b      (right_r),
    .done   (alu_done),
    .result (alu_result)
  );

  // command sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    op_nxt     = op_r;
    right_nxt  = right_r;
    strobe_nxt = 1'b0;
    word_nxt   = word_r;
    we         = 1'b0;
    waddr      = cnt_r[ADDR_W-1:0];
    wdata      = in_word.operand_value;
    alu_ctl.start = 1'b0;
    alu_ctl.op    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          strobe_nxt        = 1'b1;
          word_nxt.top_value = '0;
          word_nxt.status    = ST_OK;
          word_nxt.is_final  = 1'b0;
          unique case (in_word.command)
            CMD_PUSH: begin
              if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                word_nxt.status = ST_OVERFLOW;
              end else begin
                we                 = 1'b1;
                cnt_nxt            = cnt_r + CNT_W'(1);
                word_nxt.top_value = in_word.operand_value;
              end
            end
            CMD_FINISH: begin
              if (cnt_r == '0) begin
                word_nxt.status = ST_UNDERFLOW;
              end else begin
                strobe_nxt = 1'b0;
                cnt_nxt    = cnt_m1;
                state_nxt  = S_FIN;
              end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
              if (cnt_r < CNT_W'(2)) begin
                word_nxt.status = ST_UNDERFLOW;
              end else begin
                strobe_nxt = 1'b0;
                op_nxt     = in_word.command;
                state_nxt  = S_RD_L;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_L: begin
        right_nxt = rdata;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if ((op_r == CMD_DIV) && (right_r == '0)) begin
          strobe_nxt         = 1'b1;
          word_nxt.top_value = '0;
          word_nxt.status    = ST_DIVZERO;
          word_nxt.is_final  = 1'b0;
          state_nxt          = S_IDLE;
        end else begin
          alu_ctl.start = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (alu_done) begin
          we                 = 1'b1;
          waddr              = cnt_m2[ADDR_W-1:0];
          wdata              = alu_result;
          cnt_nxt            = cnt_m1;
          strobe_nxt         = 1'b1;
          word_nxt.top_value = alu_result;
          word_nxt.status    = ST_OK;
          word_nxt.is_final  = 1'b0;
          state_nxt          = S_IDLE;
        end
      end
      S_FIN: begin
        strobe_nxt         = 1'b1;
        word_nxt.top_value = rdata;
        word_nxt.status    = ST_OK;
        word_nxt.is_final  = 1'b1;
        state_nxt          = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
    op_r    <= op_nxt;
    right_r <= right_nxt;
    word_r  <= word_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_word   = word_r;

endmodule

FILE: tb/tb.sv
module tb;
  import psev_pkg::*;

  localparam int DEPTH           = STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WORDS_PER_PHASE = 325;
  localparam int N_PHASES        = 4;
  localparam int MAX_REPORTS     = 10;

  logic      clk;
  logic      rst_n;
  logic      start = 1'b0;
  logic      busy;
  psev_in_t  in_word = '0;
  logic      out_strobe;
  psev_out_t out_word;

  // words waiting to be sent, results waiting to arrive
  psev_in_t  token_q[$];
  psev_out_t result_q[$];

  // shadow of the operand stack
  logic [DATA_W-1:0] shadow_stack [DEPTH];
  int unsigned       shadow_count = 0;

  int idle_pct    = 0;
  int mismatches  = 0;
  int cycle_count = 0;
  int queued_ops  = 0;

  postfix_stack_evaluator_unit #(
    .STACK_DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // evaluate one token against the shadow stack
  function automatic psev_out_t eval_token(psev_in_t tok);
    psev_out_t         r;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] res;
    longint            quo;
    r = '0;
    case (tok.command)
      CMD_PUSH: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          shadow_stack[shadow_count] = tok.operand_value;
          shadow_count++;
          r.top_value = tok.operand_value;
        end
      end
      CMD_FINISH: begin
        if (shadow_count == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          shadow_count--;
          r.top_value = shadow_stack[shadow_count];
          r.is_final  = 1'b1;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (shadow_count < 2) begin
          r.status = ST_UNDERFLOW;
        end else begin
          rhs = shadow_stack[shadow_count-1];
          lhs = shadow_stack[shadow_count-2];
          if (tok.command == CMD_DIV && rhs == '0) begin
            r.status = ST_DIVZERO;
          end else begin
            case (tok.command)
              CMD_ADD: res = lhs + rhs;
              CMD_SUB: res = lhs - rhs;
              CMD_MUL: res = lhs * rhs;
              default: begin
                // 64-bit quotient so min / -1 wraps back to min
                quo = longint'($signed(lhs)) / longint'($signed(rhs));
                res = quo[DATA_W-1:0];
              end
            endcase
            shadow_count--;
            shadow_stack[shadow_count-1] = res;
            r.top_value = res;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // operand values biased toward edges and small numbers
  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 25) return DATA_W'($urandom_range(0, 18)) - DATA_W'(9);
    if (roll < 30) return {1'b1, {(DATA_W-1){1'b0}}};
    if (roll < 35) return {1'b0, {(DATA_W-1){1'b1}}};
    if (roll < 40) return '1;
    if (roll < 45) return DATA_W'(1);
    return $urandom;
  endfunction

  task automatic add_token(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
    psev_in_t tok;
    tok.command       = cmd;
    tok.operand_value = val;
    token_q.push_back(tok);
    if (cmd <= CMD_FINISH)
      queued_ops++;
  endtask

  // well-formed expression ending in a finish
  task automatic add_expression();
    int n_vals;
    int pushed;
    int live;
    n_vals = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
    pushed = 0;
    live   = 0;
    while (pushed < n_vals || live > 1) begin
      if (pushed < n_vals && (live < 2 || $urandom_range(0, 1) == 1)) begin
        add_token(CMD_PUSH, pick_value());
        pushed++;
        live++;
      end else begin
        add_token(CMD_W'(CMD_ADD + $urandom_range(0, 3)), $urandom);
        live--;
      end
    end
    add_token(CMD_FINISH, $urandom);
  endtask

  // push past full, then pop past empty
  task automatic add_fill_drain();
    for (int i = 0; i < DEPTH + 6; i++)
      add_token(CMD_PUSH, pick_value());
    for (int i = 0; i < DEPTH + 8; i++)
      add_token(($urandom_range(0, 4) == 0) ? CMD_W'(CMD_ADD + $urandom_range(0, 3))
                                            : CMD_FINISH, $urandom);
  endtask

  // any command code, any value
  task automatic add_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      add_token(CMD_W'($urandom_range(0, 7)), $urandom);
  endtask

  // hold until everything sent has come back
  task automatic wait_drained();
    @(negedge clk);
    while (token_q.size() != 0 || start || result_q.size() != 0)
      @(negedge clk);
  endtask

  // stimulus and end of run
  initial begin
    int pct [N_PHASES];
    int roll;
    pct = '{0, 85, 0, 24};
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words: empty stack, one entry, divide by zero, wraps, unused codes
    add_token(CMD_FINISH, '0);
    add_token(CMD_ADD, '0);
    add_token(CMD_PUSH, DATA_W'(7));
    add_token(CMD_MUL, '1);
    add_token(CMD_PUSH, '0);
    add_token(CMD_DIV, '0);
    add_token(CMD_FINISH, '0);
    add_token(CMD_PUSH, -DATA_W'(3));
    add_token(CMD_DIV, '0);
    add_token(CMD_PUSH, {1'b0, {(DATA_W-1){1'b1}}});
    add_token(CMD_PUSH, DATA_W'(1));
    add_token(CMD_ADD, '0);
    add_token(CMD_PUSH, '1);
    add_token(CMD_DIV, '0);
    add_token(CMD_SUB, '0);
    add_token(CMD_PUSH, {1'b1, {(DATA_W-1){1'b0}}});
    add_token(CMD_MUL, '0);
    add_token(CMD_W'(6), '0);
    add_token(CMD_W'(7), '1);
    add_token(CMD_PUSH, DATA_W'(32'h1234_5678));
    add_token(CMD_PUSH, DATA_W'(2));
    add_token(CMD_FINISH, '0);
    add_token(CMD_FINISH, '0);
    add_token(CMD_FINISH, '0);
    add_token(CMD_FINISH, '0);
    wait_drained();

    // random phases with different sender gaps
    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_pct   = pct[ph];
      queued_ops = 0;
      while (queued_ops < WORDS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 80)
          add_expression();
        else if (roll < 82)
          add_fill_drain();
        else
          add_noise();
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && result_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (token_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start   <= 1'b1;
        in_word <= token_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // predict on accept, check on strobe
  always @(posedge clk) begin
    psev_out_t want;
    if (rst_n) begin
      if (start && !busy)
        result_q.push_back(eval_token(in_word));
      if (out_strobe) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: top %h status %0d final %0b",
                     out_word.top_value, out_word.status, out_word.is_final);
        end else begin
          want = result_q.pop_front();
          if (out_word.top_value !== want.top_value || out_word.status !== want.status ||
              out_word.is_final !== want.is_final) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result mismatch: want top %h status %0d final %0b, got top %h status %0d final %0b",
                       want.top_value, want.status, want.is_final,
                       out_word.top_value, out_word.status, out_word.is_final);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
